// ----- rtl/core/psrc_pkg.sv -----
// ----------------------------------------------------------------------------
// psrc_pkg: pedal speed ramp controller package
// Field widths, register reset values, fixed-point reciprocal constants and
// the structs passed between the pipeline modules.
// ----------------------------------------------------------------------------
package psrc_pkg;

    // Field widths
    localparam int unsigned RAW_W      = 12;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned DB_W       = 7;
    localparam int unsigned STEP_W     = 12;
    localparam int unsigned GAIN_W     = 12;
    localparam int unsigned SPEED_W    = 18;
    localparam int unsigned DISP_W     = 9;
    localparam int unsigned PWM_W      = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 18;

    // Window defaults
    localparam int unsigned SAMPLES_DEF = 16;
    localparam int unsigned UPDATES_DEF = 16;

    // Scaling constants
    localparam int unsigned FULL_SCALE_RAW = 4020;
    localparam int unsigned RAW_SCALE      = 100;
    localparam int unsigned GAIN_DIV       = 100;
    localparam int unsigned SPEED_UNIT     = 1000;
    localparam int unsigned PWM_TOP        = 65535;
    localparam int unsigned DISPLAY_SPAN   = 220;
    localparam int unsigned SPEED_MAX      = (1 << SPEED_W) - 1;
    localparam int unsigned RAW_MAX        = (1 << RAW_W) - 1;
    localparam int unsigned PCT_MAX        = RAW_MAX * RAW_SCALE / FULL_SCALE_RAW;

    // Division by a constant d: for x < 2**N, floor(x/d) equals
    // (x * ceil(2**(N+l)/d)) >> (N+l) with l = clog2(d).

    // raw*100/4020, the *100 folded into the multiplier
    localparam int unsigned     PCT_N      = $clog2(RAW_MAX * RAW_SCALE + 1);
    localparam int unsigned     PCT_SHIFT  = PCT_N + $clog2(FULL_SCALE_RAW);
    localparam longint unsigned PCT_MULT   =
        (((64'd1 << PCT_SHIFT) + FULL_SCALE_RAW - 1) / FULL_SCALE_RAW) * RAW_SCALE;
    localparam int unsigned     PCT_PROD_W = PCT_SHIFT + PCT_W;

    // avg_percent*gain/100
    localparam int unsigned     GAIN_N      = $clog2(PCT_MAX * ((1 << GAIN_W) - 1) + 1);
    localparam int unsigned     GAIN_SHIFT  = GAIN_N + $clog2(GAIN_DIV);
    localparam longint unsigned GAIN_MULT   =
        ((64'd1 << GAIN_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
    localparam int unsigned     DELTA_W     =
        $clog2(PCT_MAX * ((1 << GAIN_W) - 1) / GAIN_DIV + 1);
    localparam int unsigned     GAIN_PROD_W = GAIN_SHIFT + DELTA_W;

    // avg_speed/1000
    localparam int unsigned     UNIT_SHIFT  = SPEED_W + $clog2(SPEED_UNIT);
    localparam longint unsigned UNIT_MULT   =
        ((64'd1 << UNIT_SHIFT) + SPEED_UNIT - 1) / SPEED_UNIT;
    localparam int unsigned     UNIT_PROD_W = UNIT_SHIFT + DISP_W;

    // display*65535/220
    localparam int unsigned     PWM_N      = $clog2(((1 << DISP_W) - 1) * PWM_TOP + 1);
    localparam int unsigned     PWM_SHIFT  = PWM_N + $clog2(DISPLAY_SPAN);
    localparam longint unsigned PWM_MULT   =
        ((64'd1 << PWM_SHIFT) + DISPLAY_SPAN - 1) / DISPLAY_SPAN;
    localparam int unsigned     PWM_Q_W    =
        $clog2(((1 << DISP_W) - 1) * PWM_TOP / DISPLAY_SPAN + 1);
    localparam int unsigned     PWM_PROD_W = PWM_SHIFT + PWM_Q_W;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEADBAND   = 3'd0,
        REG_COAST_STEP = 3'd1,
        REG_LOW_LIMIT  = 3'd2,
        REG_HIGH_LIMIT = 3'd3,
        REG_LOW_GAIN   = 3'd4,
        REG_HIGH_GAIN  = 3'd5,
        REG_BRAKE_GAIN = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [DB_W-1:0]    deadband;
        logic [STEP_W-1:0]  coast_step;
        logic [SPEED_W-1:0] low_limit;
        logic [SPEED_W-1:0] high_limit;
        logic [GAIN_W-1:0]  low_gain;
        logic [GAIN_W-1:0]  high_gain;
        logic [GAIN_W-1:0]  brake_gain;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        deadband:   DB_W'(15),
        coast_step: STEP_W'(400),
        low_limit:  SPEED_W'(80000),
        high_limit: SPEED_W'(200000),
        low_gain:   GAIN_W'(1600),
        high_gain:  GAIN_W'(3200),
        brake_gain: GAIN_W'(3200)
    };

    // Averaged pedals of one closed sample window
    typedef struct packed {
        logic             ev;
        logic             park;
        logic             high;
        logic [PCT_W-1:0] t_avg;
        logic [PCT_W-1:0] b_avg;
    } pedal_t;

    // Speed after one update
    typedef struct packed {
        logic               ev;
        logic [SPEED_W-1:0] speed;
    } speed_t;

    // One result word
    typedef struct packed {
        logic               ev;
        logic [SPEED_W-1:0] speed;
        logic               disp_valid;
        logic [DISP_W-1:0]  disp;
        logic [PWM_W-1:0]   pwm;
    } result_t;

endpackage

// ----- rtl/core/psrc_pedal_front.sv -----
// ----------------------------------------------------------------------------
// psrc_pedal_front: pedal scaling and sample window
// Scales both samples to percent with deadband, sums them over the sample
// window and averages the sums when the window closes.
// ----------------------------------------------------------------------------
module psrc_pedal_front
    import psrc_pkg::*;
#(
    parameter int unsigned SAMPLES = SAMPLES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAW_W-1:0] throttle_raw,
    input  logic [RAW_W-1:0] brake_raw,
    input  logic             park_pin,
    input  logic             high_gear_pin,
    input  logic [DB_W-1:0]  deadband,
    output pedal_t           pedal
);

    localparam int unsigned     SUM_W      = $clog2(PCT_MAX * SAMPLES + 1);
    localparam int unsigned     CNT_W      = $clog2(SAMPLES);
    localparam int unsigned     AVG_SHIFT  = SUM_W + $clog2(SAMPLES);
    localparam longint unsigned AVG_MULT   = ((64'd1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES;
    localparam int unsigned     AVG_PROD_W = AVG_SHIFT + PCT_W;

    function automatic logic [PCT_W-1:0] to_percent(input logic [RAW_W-1:0] raw,
                                                    input logic [DB_W-1:0]  db);
        logic [PCT_PROD_W-1:0] prod;
        logic [PCT_W-1:0]      pct;
        prod = PCT_PROD_W'(raw) * PCT_PROD_W'(PCT_MULT);
        pct  = prod[PCT_SHIFT +: PCT_W];
        return (pct < db) ? '0 : pct;
    endfunction

    // Stage A: percents
    logic             a_valid_reg;
    logic [PCT_W-1:0] a_tpct_reg, a_bpct_reg;
    logic             a_park_reg, a_high_reg;

    // Stage B: window sums
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] tsum_reg, tsum_next, bsum_reg, bsum_next;
    logic [SUM_W-1:0] tacc, bacc;
    logic             last;
    logic             b_ev_reg;
    logic [SUM_W-1:0] b_ttot_reg, b_btot_reg;
    logic             b_park_reg, b_high_reg;

    // Stage C: averages
    logic [AVG_PROD_W-1:0] t_prod, b_prod;
    pedal_t                pedal_reg, pedal_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tpct_reg <= to_percent(throttle_raw, deadband);
            a_bpct_reg <= to_percent(brake_raw, deadband);
            a_park_reg <= park_pin;
            a_high_reg <= high_gear_pin;
        end
    end

    always_comb begin
        tacc      = tsum_reg + SUM_W'(a_tpct_reg);
        bacc      = bsum_reg + SUM_W'(a_bpct_reg);
        last      = a_valid_reg && (cnt_reg == CNT_W'(SAMPLES - 1));
        cnt_next  = cnt_reg;
        tsum_next = tsum_reg;
        bsum_next = bsum_reg;
        if (last) begin
            cnt_next  = '0;
            tsum_next = '0;
            bsum_next = '0;
        end else if (a_valid_reg) begin
            cnt_next  = cnt_reg + 1'b1;
            tsum_next = tacc;
            bsum_next = bacc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            tsum_reg <= '0;
            bsum_reg <= '0;
            b_ev_reg <= 1'b0;
        end else if (en) begin
            cnt_reg  <= cnt_next;
            tsum_reg <= tsum_next;
            bsum_reg <= bsum_next;
            b_ev_reg <= last;
        end
    end

    // Window totals and gear pins of the item that closes the window
    always_ff @(posedge aclk) begin
        if (en) begin
            b_ttot_reg <= tacc;
            b_btot_reg <= bacc;
            b_park_reg <= a_park_reg;
            b_high_reg <= a_high_reg;
        end
    end

    always_comb begin
        t_prod           = AVG_PROD_W'(b_ttot_reg) * AVG_PROD_W'(AVG_MULT);
        b_prod           = AVG_PROD_W'(b_btot_reg) * AVG_PROD_W'(AVG_MULT);
        pedal_next.ev    = b_ev_reg;
        pedal_next.park  = b_park_reg;
        pedal_next.high  = b_high_reg;
        pedal_next.t_avg = t_prod[AVG_SHIFT +: PCT_W];
        pedal_next.b_avg = b_prod[AVG_SHIFT +: PCT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pedal_reg <= '0;
        end else if (en) begin
            pedal_reg <= pedal_next;
        end
    end

    assign pedal = pedal_reg;

endmodule

// ----- rtl/core/psrc_speed_update.sv -----
// ----------------------------------------------------------------------------
// psrc_speed_update: speed ramp
// Turns averaged pedals into a speed step and applies it to the stored speed,
// clamped to the gear limit; park instead coasts down by the coast step.
// ----------------------------------------------------------------------------
module psrc_speed_update
    import psrc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  cfg_t   cfg,
    input  pedal_t pedal,
    output speed_t speed_out
);

    // Stage D: gain products
    logic              d_ev_reg, d_park_reg, d_high_reg, d_tpos_reg, d_bpos_reg;
    logic [GAIN_N-1:0] d_tprod_reg, d_bprod_reg;
    logic [GAIN_W-1:0] gain_sel;

    // Stage E: steps
    logic                   e_ev_reg, e_park_reg, e_high_reg, e_tpos_reg, e_bpos_reg;
    logic [DELTA_W-1:0]     e_dt_reg, e_db_reg;
    logic [GAIN_PROD_W-1:0] t_div, b_div;

    // Stage F: speed
    logic                   f_ev_reg;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [SPEED_W:0]       raised;
    logic [SPEED_W-1:0]     lowered, held, limit;

    assign gain_sel = pedal.high ? cfg.high_gain : cfg.low_gain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_ev_reg <= 1'b0;
            e_ev_reg <= 1'b0;
            f_ev_reg <= 1'b0;
        end else if (en) begin
            d_ev_reg <= pedal.ev;
            e_ev_reg <= d_ev_reg;
            f_ev_reg <= e_ev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_park_reg  <= pedal.park;
            d_high_reg  <= pedal.high;
            d_tpos_reg  <= (pedal.t_avg != '0);
            d_bpos_reg  <= (pedal.b_avg != '0);
            d_tprod_reg <= GAIN_N'(pedal.t_avg) * GAIN_N'(gain_sel);
            d_bprod_reg <= GAIN_N'(pedal.b_avg) * GAIN_N'(cfg.brake_gain);
        end
    end

    assign t_div = GAIN_PROD_W'(d_tprod_reg) * GAIN_PROD_W'(GAIN_MULT);
    assign b_div = GAIN_PROD_W'(d_bprod_reg) * GAIN_PROD_W'(GAIN_MULT);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_park_reg <= d_park_reg;
            e_high_reg <= d_high_reg;
            e_tpos_reg <= d_tpos_reg;
            e_bpos_reg <= d_bpos_reg;
            e_dt_reg   <= t_div[GAIN_SHIFT +: DELTA_W];
            e_db_reg   <= b_div[GAIN_SHIFT +: DELTA_W];
        end
    end

    // Park coasts down to zero and ignores the limit; in gear clamp to 0..limit.
    always_comb begin
        limit   = e_high_reg ? cfg.high_limit : cfg.low_limit;
        raised  = (SPEED_W + 1)'(speed_reg) + (SPEED_W + 1)'(e_dt_reg);
        lowered = (SPEED_W'(e_db_reg) > speed_reg) ? '0 : speed_reg - SPEED_W'(e_db_reg);
        if (e_tpos_reg && !e_bpos_reg) begin
            held = (raised > (SPEED_W + 1)'(limit)) ? limit : raised[SPEED_W-1:0];
        end else if (e_bpos_reg && !e_tpos_reg) begin
            held = (lowered > limit) ? limit : lowered;
        end else begin
            held = (speed_reg > limit) ? limit : speed_reg;
        end
        if (e_park_reg) begin
            speed_next = (SPEED_W'(cfg.coast_step) > speed_reg) ?
                         '0 : speed_reg - SPEED_W'(cfg.coast_step);
        end else begin
            speed_next = held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
        end else if (en && e_ev_reg) begin
            speed_reg <= speed_next;
        end
    end

    assign speed_out.ev    = f_ev_reg;
    assign speed_out.speed = speed_reg;

endmodule

// ----- rtl/core/psrc_display.sv -----
// ----------------------------------------------------------------------------
// psrc_display: display window
// Averages the updated speed over the display window, scales it to display
// units and maps it to a saturated PWM compare value.
// ----------------------------------------------------------------------------
module psrc_display
    import psrc_pkg::*;
#(
    parameter int unsigned UPDATES = UPDATES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  speed_t  speed_in,
    output result_t result
);

    localparam int unsigned     SUM_W      = $clog2(SPEED_MAX * UPDATES + 1);
    localparam int unsigned     CNT_W      = $clog2(UPDATES);
    localparam int unsigned     AVG_SHIFT  = SUM_W + $clog2(UPDATES);
    localparam longint unsigned AVG_MULT   = ((64'd1 << AVG_SHIFT) + UPDATES - 1) / UPDATES;
    localparam int unsigned     AVG_PROD_W = AVG_SHIFT + SPEED_W;

    // Stage G: speed sum
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next, acc;
    logic               last;
    logic               g_ev_reg, g_win_reg;
    logic [SPEED_W-1:0] g_speed_reg;
    logic [SUM_W-1:0]   g_total_reg;

    // Stage H: average speed
    logic                  h_ev_reg, h_win_reg;
    logic [SPEED_W-1:0]    h_speed_reg, h_avg_reg;
    logic [AVG_PROD_W-1:0] avg_prod;

    // Stage I: display speed
    logic                   i_ev_reg, i_win_reg;
    logic [SPEED_W-1:0]     i_speed_reg;
    logic [DISP_W-1:0]      i_disp_reg;
    logic [UNIT_PROD_W-1:0] unit_prod;

    // PWM mapping
    logic [PWM_N-1:0]      pwm_scaled;
    logic [PWM_PROD_W-1:0] pwm_prod;
    logic [PWM_Q_W-1:0]    pwm_q;

    always_comb begin
        acc      = sum_reg + SUM_W'(speed_in.speed);
        last     = speed_in.ev && (cnt_reg == CNT_W'(UPDATES - 1));
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (last) begin
            cnt_next = '0;
            sum_next = '0;
        end else if (speed_in.ev) begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            g_ev_reg <= 1'b0;
            h_ev_reg <= 1'b0;
            i_ev_reg <= 1'b0;
        end else if (en) begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            g_ev_reg <= speed_in.ev;
            h_ev_reg <= g_ev_reg;
            i_ev_reg <= h_ev_reg;
        end
    end

    assign avg_prod  = AVG_PROD_W'(g_total_reg) * AVG_PROD_W'(AVG_MULT);
    assign unit_prod = UNIT_PROD_W'(h_avg_reg) * UNIT_PROD_W'(UNIT_MULT);

    always_ff @(posedge aclk) begin
        if (en) begin
            g_win_reg   <= last;
            g_speed_reg <= speed_in.speed;
            g_total_reg <= acc;
            h_win_reg   <= g_win_reg;
            h_speed_reg <= g_speed_reg;
            h_avg_reg   <= avg_prod[AVG_SHIFT +: SPEED_W];
            i_win_reg   <= h_win_reg;
            i_speed_reg <= h_speed_reg;
            i_disp_reg  <= unit_prod[UNIT_SHIFT +: DISP_W];
        end
    end

    // disp * 65535 as shift and subtract, then divide by the span
    always_comb begin
        pwm_scaled = PWM_N'({i_disp_reg, {PWM_W{1'b0}}}) - PWM_N'(i_disp_reg);
        pwm_prod   = PWM_PROD_W'(pwm_scaled) * PWM_PROD_W'(PWM_MULT);
        pwm_q      = pwm_prod[PWM_SHIFT +: PWM_Q_W];
        result.ev         = i_ev_reg;
        result.speed      = i_speed_reg;
        result.disp_valid = i_win_reg;
        result.disp       = i_win_reg ? i_disp_reg : '0;
        if (!i_win_reg) begin
            result.pwm = '0;
        end else if (pwm_q > PWM_Q_W'(PWM_TOP)) begin
            result.pwm = PWM_W'(PWM_TOP);
        end else begin
            result.pwm = pwm_q[PWM_W-1:0];
        end
    end

endmodule

// ----- rtl/core/pedal_speed_ramp_controller.sv -----
// ----------------------------------------------------------------------------
// pedal_speed_ramp_controller: pedal driven speed ramp
// Window-averaged throttle and brake pedals ramp a stored speed per gear;
// the speed is also averaged for a display value and a PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per converter sample pair with the two gear pins.
//   m_ channel: one word per SAMPLES_PER_UPDATE input words, carrying the
//   updated speed; every UPDATES_PER_DISPLAY results m_tuser is set and the
//   display speed and PWM compare fields are filled, else they read zero.
//   cfg_ port: write registers while no word is in flight.
// Throughput: one input word per cycle, sustained while no stall holds the pipeline.
// Pipeline: the word closing the sample window reaches m_ as a result through
//   the ten-stage pipeline (input register, scaling, window sum, average, gain
//   multiply, divide, speed update, speed sum, average, display scaling) plus the
//   output register.
// Stall: a result waiting on m_tready holds in the output register while the
//   pipeline keeps moving; once the next result reaches the last stage the
//   whole pipeline holds and s_tready drops; nothing is lost or repeated.
// Reset: clears the speed, both windows, the pipeline and the output word,
//   and loads the register reset values.
// ----------------------------------------------------------------------------
module pedal_speed_ramp_controller
    import psrc_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_UPDATE  = SAMPLES_DEF,
    parameter int unsigned UPDATES_PER_DISPLAY = UPDATES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] throttle_raw, [23:12] brake_raw, [24] park_pin, [25] high_gear_pin
    input  logic [31:0]           s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [17:0] desired_speed, [26:18] display_speed, [42:27] pwm_compare
    output logic [47:0]           m_tdata,
    // [0] display_valid
    output logic                  m_tuser
);

    cfg_t    cfg_reg;
    logic    adv;
    logic    out_free;

    logic             in_valid_reg;
    logic [RAW_W-1:0] in_throttle_reg, in_brake_reg;
    logic             in_park_reg, in_high_reg;

    pedal_t  pedal;
    speed_t  speed;
    result_t result;
    result_t out_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DEADBAND:   cfg_reg.deadband   <= cfg_wdata[DB_W-1:0];
                REG_COAST_STEP: cfg_reg.coast_step <= cfg_wdata[STEP_W-1:0];
                REG_LOW_LIMIT:  cfg_reg.low_limit  <= cfg_wdata[SPEED_W-1:0];
                REG_HIGH_LIMIT: cfg_reg.high_limit <= cfg_wdata[SPEED_W-1:0];
                REG_LOW_GAIN:   cfg_reg.low_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_HIGH_GAIN:  cfg_reg.high_gain  <= cfg_wdata[GAIN_W-1:0];
                REG_BRAKE_GAIN: cfg_reg.brake_gain <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the pipeline unless a new result would land on a waiting one
    assign out_free = !out_reg.ev || m_tready;
    assign adv      = out_free || !result.ev;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_throttle_reg <= s_tdata[RAW_W-1:0];
            in_brake_reg    <= s_tdata[2*RAW_W-1:RAW_W];
            in_park_reg     <= s_tdata[2*RAW_W];
            in_high_reg     <= s_tdata[2*RAW_W+1];
        end
    end

    psrc_pedal_front #(
        .SAMPLES (SAMPLES_PER_UPDATE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (in_valid_reg),
        .throttle_raw  (in_throttle_reg),
        .brake_raw     (in_brake_reg),
        .park_pin      (in_park_reg),
        .high_gear_pin (in_high_reg),
        .deadband      (cfg_reg.deadband),
        .pedal         (pedal)
    );

    psrc_speed_update u_speed (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .cfg       (cfg_reg),
        .pedal     (pedal),
        .speed_out (speed)
    );

    psrc_display #(
        .UPDATES (UPDATES_PER_DISPLAY)
    ) u_display (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .speed_in (speed),
        .result   (result)
    );

    // Drop bubbles while a result waits; load whenever the output word is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (out_free) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_reg.ev;
    assign m_tuser  = out_reg.disp_valid;
    assign m_tdata  = {5'd0, out_reg.pwm, out_reg.disp, out_reg.speed};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pedal speed ramp controller
// Each sample word is also run through a local ramp predictor. Every result
// word is checked field by field against the oldest predicted readout. A
// directed table comes first, one sample window per row, with a few speeds
// typed in. Random phases follow, each with new register settings.
// ----------------------------------------------------------------------------
module testbench;
    import psrc_pkg::*;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned WINDOW         = SAMPLES_DEF;
    localparam int unsigned DISPLAY_WINDOW = UPDATES_DEF;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned LONG_HOLD      = 200;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned PHASES         = 7;
    localparam int unsigned SPRINT_PHASE   = 3;
    localparam int unsigned SPRINT_BURSTS  = 64;
    localparam int unsigned CRUISE_BURSTS  = 3;
    localparam int unsigned GAIN_TOP       = (1 << GAIN_W) - 1;
    localparam int unsigned SPRINT_DEADBAND = 20;

    // index past the last register, must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // gear pins as {high_gear_pin, park_pin}
    localparam logic [1:0] PINS_LOW       = 2'b00;
    localparam logic [1:0] PINS_PARK      = 2'b01;
    localparam logic [1:0] PINS_HIGH      = 2'b10;
    localparam logic [1:0] PINS_PARK_HIGH = 2'b11;

    typedef enum int {
        PLAN_THROTTLE,
        PLAN_BRAKE,
        PLAN_BOTH,
        PLAN_RELEASED,
        PLAN_PARK,
        PLAN_NOISE,
        PLAN_SPRINT
    } drive_plan_t;

    typedef struct packed {
        logic             high;
        logic             park;
        logic [RAW_W-1:0] brake;
        logic [RAW_W-1:0] throttle;
    } pedal_sample_t;

    localparam int unsigned SAMPLE_W = $bits(pedal_sample_t);

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               shown;
        logic [DISP_W-1:0]  disp;
        logic [PWM_W-1:0]   pwm;
    } readout_t;

    typedef struct packed {
        logic                  wr;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [RAW_W-1:0]      throttle;
        logic [RAW_W-1:0]      brake;
        logic [1:0]            pins;
        logic [1:0]            last_pins;
        logic                  typed;
        logic [SPEED_W-1:0]    speed;
    } window_row_t;

    // One row fills one sample window; pins of the closing word are separate.
    localparam int unsigned DIR_ROWS = 21;
    localparam window_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_PARK,      PINS_PARK,
          1'b1, 18'd0},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd1616},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd3232},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd4095, PINS_LOW,       PINS_LOW,
          1'b1, 18'd3232},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd0,    12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b1, 18'd3232},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd602,  12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd3232},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd603,  12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd3472},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_PARK_HIGH, PINS_HIGH,
          1'b0, 18'd0},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd0,    12'd4095, PINS_LOW,       PINS_LOW,
          1'b0, 18'd0},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd4020, 12'd0,    PINS_PARK,      PINS_PARK,
          1'b0, 18'd0},
        '{1'b1, REG_LOW_LIMIT,  18'd0,      12'd0,    12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd0},
        '{1'b1, REG_UNUSED,     18'h3FFFF,  12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b1, REG_DEADBAND,   18'd127,    12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b1, REG_DEADBAND,   18'd0,      12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b1, REG_HIGH_GAIN,  18'd4095,   12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b1, REG_BRAKE_GAIN, 18'd4095,   12'd0,    12'd4095, PINS_HIGH,      PINS_HIGH,
          1'b0, 18'd0},
        '{1'b1, REG_COAST_STEP, 18'd4095,   12'd0,    12'd0,    PINS_PARK,      PINS_PARK,
          1'b0, 18'd0},
        '{1'b0, REG_DEADBAND,   18'd0,      12'd0,    12'd0,    PINS_PARK,      PINS_PARK,
          1'b1, 18'd0},
        '{1'b1, REG_LOW_GAIN,   18'd0,      12'd4095, 12'd0,    PINS_LOW,       PINS_LOW,
          1'b1, 18'd0},
        '{1'b1, REG_HIGH_LIMIT, 18'd0,      12'd4095, 12'd0,    PINS_HIGH,      PINS_HIGH,
          1'b1, 18'd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  m_tuser;

    // predictor state
    cfg_t            model_cfg = CFG_RST;
    int unsigned     window_fill = 0;
    int unsigned     throttle_total = 0;
    int unsigned     brake_total = 0;
    int unsigned     speed_now = 0;
    int unsigned     display_fill = 0;
    longint unsigned speed_total = 0;

    readout_t    pending_readouts[$];
    int unsigned readouts_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_long = 1'b0;

    pedal_speed_ramp_controller #(
        .SAMPLES_PER_UPDATE  (WINDOW),
        .UPDATES_PER_DISPLAY (DISPLAY_WINDOW)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned pedal_percent(input logic [RAW_W-1:0] raw);
        int unsigned pct;
        pct = raw * RAW_SCALE / FULL_SCALE_RAW;
        return (pct < model_cfg.deadband) ? 0 : pct;
    endfunction

    // Accumulate one sample word; queue a readout when it closes a window.
    task automatic advance_ramp(input pedal_sample_t smp);
        int unsigned     t_avg;
        int unsigned     b_avg;
        int unsigned     gain;
        longint          s;
        longint          lim;
        longint unsigned pwm_full;
        readout_t        r;
        throttle_total += pedal_percent(smp.throttle);
        brake_total += pedal_percent(smp.brake);
        window_fill++;
        if (window_fill < WINDOW)
            return;
        t_avg = throttle_total / WINDOW;
        b_avg = brake_total / WINDOW;
        window_fill = 0;
        throttle_total = 0;
        brake_total = 0;

        s = longint'(speed_now);
        if (smp.park) begin
            s = s - longint'(model_cfg.coast_step);
        end else begin
            lim = smp.high ? longint'(model_cfg.high_limit) : longint'(model_cfg.low_limit);
            gain = 32'(smp.high ? model_cfg.high_gain : model_cfg.low_gain);
            if (t_avg > 0 && b_avg == 0)
                s = s + longint'(t_avg * gain / GAIN_DIV);
            else if (b_avg > 0 && t_avg == 0)
                s = s - longint'(b_avg * model_cfg.brake_gain / GAIN_DIV);
            if (s > lim)
                s = lim;
        end
        if (s < 0)
            s = 0;
        speed_now = int'(s);

        r = '0;
        r.speed = SPEED_W'(speed_now);
        speed_total += speed_now;
        display_fill++;
        if (display_fill >= DISPLAY_WINDOW) begin
            r.shown = 1'b1;
            r.disp = DISP_W'(speed_total / DISPLAY_WINDOW / SPEED_UNIT);
            pwm_full = longint'(r.disp) * PWM_TOP / DISPLAY_SPAN;
            r.pwm = (pwm_full > PWM_TOP) ? PWM_W'(PWM_TOP) : PWM_W'(pwm_full);
            display_fill = 0;
            speed_total = 0;
        end
        pending_readouts.push_back(r);
    endtask

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got === want)
            return 1'b0;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    task automatic check_readout(input readout_t got);
        readout_t want;
        bit       bad;
        if (pending_readouts.size() == 0) begin
            $display("%0t: speed expected none got %0d", $time, got.speed);
            mismatches++;
            return;
        end
        want = pending_readouts.pop_front();
        if (readouts_seen < DIR_ROWS && DIR_TABLE[readouts_seen].typed)
            want.speed = DIR_TABLE[readouts_seen].speed;
        readouts_seen++;
        bad = field_differs("desired_speed", 32'(want.speed), 32'(got.speed));
        bad |= field_differs("display_valid", 32'(want.shown), 32'(got.shown));
        bad |= field_differs("display_speed", 32'(want.disp), 32'(got.disp));
        bad |= field_differs("pwm_compare", 32'(want.pwm), 32'(got.pwm));
        if (bad)
            mismatches++;
    endtask

    // Predict on the accepted input word before checking the output word.
    always @(posedge aclk) begin : watch_ports
        readout_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                advance_ramp(pedal_sample_t'(s_tdata[25:0]));
            if (m_tvalid && m_tready) begin
                got.speed = m_tdata[SPEED_W-1:0];
                got.disp = m_tdata[SPEED_W +: DISP_W];
                got.pwm = m_tdata[SPEED_W+DISP_W +: PWM_W];
                got.shown = m_tuser;
                check_readout(got);
            end
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                hold_long = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input pedal_sample_t smp);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= 32'(smp);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold input until every readout is back, then let the pipeline empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_wr_en high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_DEADBAND:   model_cfg.deadband = val[DB_W-1:0];
            REG_COAST_STEP: model_cfg.coast_step = val[STEP_W-1:0];
            REG_LOW_LIMIT:  model_cfg.low_limit = val[SPEED_W-1:0];
            REG_HIGH_LIMIT: model_cfg.high_limit = val[SPEED_W-1:0];
            REG_LOW_GAIN:   model_cfg.low_gain = val[GAIN_W-1:0];
            REG_HIGH_GAIN:  model_cfg.high_gain = val[GAIN_W-1:0];
            REG_BRAKE_GAIN: model_cfg.brake_gain = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Zero, all ones or random up to rand_top; sometimes junk above the width.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int unsigned width,
                                                             input int unsigned rand_top);
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] junk;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = CFG_DATA_W'((1 << width) - 1);
            default: v = CFG_DATA_W'($urandom_range(0, rand_top));
        endcase
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            v = v | (junk << width);
        return v;
    endfunction

    task automatic configure_phase(input bit sprint);
        drain_results();
        if (sprint) begin
            write_reg(REG_DEADBAND, CFG_DATA_W'(SPRINT_DEADBAND));
            write_reg(REG_LOW_LIMIT, CFG_DATA_W'(SPEED_MAX));
            write_reg(REG_HIGH_LIMIT, CFG_DATA_W'(SPEED_MAX));
            write_reg(REG_LOW_GAIN, CFG_DATA_W'(GAIN_TOP));
            write_reg(REG_HIGH_GAIN, CFG_DATA_W'(GAIN_TOP));
        end else begin
            write_reg(REG_DEADBAND, pick_reg_value(DB_W, 40));
            write_reg(REG_LOW_LIMIT, pick_reg_value(SPEED_W, SPEED_MAX));
            write_reg(REG_HIGH_LIMIT, pick_reg_value(SPEED_W, SPEED_MAX));
            write_reg(REG_LOW_GAIN, pick_reg_value(GAIN_W, GAIN_TOP));
            write_reg(REG_HIGH_GAIN, pick_reg_value(GAIN_W, GAIN_TOP));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end
        write_reg(REG_COAST_STEP, pick_reg_value(STEP_W, GAIN_TOP));
        write_reg(REG_BRAKE_GAIN, pick_reg_value(GAIN_W, GAIN_TOP));
        cfg_wr_en <= 1'b0;
    endtask

    // A run of sample words that follow one driving plan.
    task automatic send_burst(input int unsigned count, input bit sprint);
        drive_plan_t   plan;
        logic          gear;
        pedal_sample_t smp;
        plan = sprint ? PLAN_SPRINT : drive_plan_t'($urandom_range(0, 5));
        gear = 1'($urandom_range(0, 1));
        repeat (count) begin
            case (plan)
                PLAN_SPRINT: begin
                    smp.throttle = RAW_W'($urandom_range(FULL_SCALE_RAW, RAW_MAX));
                    smp.brake = RAW_W'($urandom_range(0, 800));
                    smp.park = 1'b0;
                    smp.high = 1'($urandom_range(0, 1));
                end
                PLAN_NOISE: begin
                    smp = pedal_sample_t'(SAMPLE_W'($urandom));
                end
                default: begin
                    smp.throttle = RAW_W'((plan == PLAN_THROTTLE || plan == PLAN_BOTH) ?
                                   $urandom_range(1500, RAW_MAX) : $urandom_range(0, 300));
                    smp.brake = RAW_W'((plan == PLAN_BRAKE || plan == PLAN_BOTH) ?
                                $urandom_range(1500, RAW_MAX) : $urandom_range(0, 300));
                    smp.park = (plan == PLAN_PARK);
                    smp.high = gear;
                end
            endcase
            send_sample(smp);
        end
    endtask

    initial begin : stimulus
        pedal_sample_t smp;
        window_row_t   row;
        bit            sprint;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.wr) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
                cfg_wr_en <= 1'b0;
            end
            for (int k = 0; k < WINDOW; k++) begin
                smp.throttle = row.throttle;
                smp.brake = row.brake;
                {smp.high, smp.park} = (k == WINDOW - 1) ? row.last_pins : row.pins;
                send_sample(smp);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            sprint = (ph == SPRINT_PHASE);
            configure_phase(sprint);
            calm = (ph == PHASES - 1);
            // back up the result side while words keep coming
            if (ph == 1)
                hold_long = 1'b1;
            repeat (sprint ? SPRINT_BURSTS : CRUISE_BURSTS) send_burst(WINDOW, sprint);
            if (!sprint)
                send_burst($urandom_range(0, WINDOW - 1), 1'b0);
        end

        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
